// ===== design/variable_feedback_delay_line_core_defines.svh =====
// assertion macros
`ifndef VARIABLE_FEEDBACK_DELAY_LINE_CORE_DEFINES_SVH
`define VARIABLE_FEEDBACK_DELAY_LINE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VFDL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VFDL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VFDL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define VFDL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/vfdl_pkg.sv =====
`default_nettype none
package vfdl_pkg;
    localparam int DEPTH       = 4096;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int SAMPLE_BITS = 24;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int DIV_STEPS   = 26;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    localparam logic signed [15:0] GAIN_LIMIT = 16'sd16220;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_MS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE_ON        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_ON        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP_ON      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_ON     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTECT_ON     = 3'd7;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ADDR, S_RDA, S_RDB, S_INTERP, S_LPMUL, S_LPPREP,
        S_DIV, S_LPFIN, S_FB, S_WRITE, S_HRD, S_HCAP, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_LOAD, OP_MUTE, OP_ADDR, OP_RDA, OP_RDB, OP_INTERP,
        OP_LPMUL, OP_LPPREP, OP_DIV, OP_LPFIN, OP_FB, OP_WRITE, OP_HRD, OP_HCAP,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic mute;
        logic hold;
        logic lowpass;
        logic clr_last;
        logic div_last;
        logic out_free;
    } t_status;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [47:0] v);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = 48'sd8388607;
        lo = -48'sd8388608;
        if (v > hi) begin
            return hi[SAMPLE_BITS-1:0];
        end else if (v < lo) begin
            return lo[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== design/vfdl_if.sv =====
`default_nettype none
interface vfdl_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] in_sample;
    logic [17:0]        delay_ms;
    logic signed [15:0] feedback_gain;
    modport source (output valid, in_sample, delay_ms, feedback_gain, input ready);
    modport sink (input valid, in_sample, delay_ms, feedback_gain, output ready);
endinterface

interface vfdl_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] out_sample;
    modport source (output valid, out_sample, input ready);
    modport sink (input valid, out_sample, output ready);
endinterface
`default_nettype wire

// ===== design/vfdl_datapath.sv =====
`default_nettype none
module vfdl_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire vfdl_pkg::t_cmd                 i_cmd,
    output vfdl_pkg::t_status                   o_status,
    input  wire logic                           i_cfg_we,
    input  wire logic [vfdl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [vfdl_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_in_valid,
    input  wire logic signed [23:0]             i_in_sample,
    input  wire logic [17:0]                    i_delay_ms,
    input  wire logic signed [15:0]             i_feedback_gain,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic signed [23:0]                  o_out_sample
);
    import vfdl_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_mem_store [DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rdata;

    logic [12:0] r_len_cfg;
    logic [15:0] r_spm, r_coef;
    logic r_mute, r_hold, r_interp, r_lowpass, r_protect;

    logic [ADDR_W-1:0] r_w, r_clr_addr, r_ia, r_ib;
    logic signed [SAMPLE_BITS-1:0] r_filt, r_x, r_a, r_res, r_wv, r_out;
    logic signed [15:0] r_g;
    logic [33:0] r_prod;
    logic [15:0] r_f;
    logic signed [41:0] r_num;
    logic r_neg;
    logic [16:0] r_rem;
    logic [DIV_STEPS-1:0] r_q;
    logic [CNT_W-1:0] r_cnt;
    logic r_out_valid;

    logic [LEN_W-1:0] len, w_eff, nw, dd, ia_full, ib_full;
    logic [17:0] dint;
    logic [15:0] fr;
    logic signed [15:0] g_cl;
    logic [16:0] den;
    logic we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic signed [SAMPLE_BITS-1:0] wdata;
    logic signed [24:0] diff;
    logic signed [42:0] iprod, isum;
    logic signed [41:0] num;
    logic [41:0] nmag;
    logic [17:0] rem2;
    logic ge;
    logic signed [26:0] qs;
    logic signed [39:0] fprod, fsh;

    always_comb begin
        if (r_len_cfg < 13'd2) begin
            len = 13'd2;
        end else if (r_len_cfg > 13'(DEPTH)) begin
            len = 13'(DEPTH);
        end else begin
            len = r_len_cfg;
        end
        w_eff = ({1'b0, r_w} >= len) ? '0 : {1'b0, r_w};
        nw = {1'b0, r_w} + 13'd1;
        if (nw >= len) begin
            nw = '0;
        end
        dint = r_prod[33:16];
        fr   = r_prod[15:0];
        if (dint >= 18'(len)) begin
            dd = len - 13'd1;
            fr = '0;
        end else begin
            dd = dint[LEN_W-1:0];
        end
        ia_full = ({1'b0, r_w} >= dd) ? ({1'b0, r_w} - dd) : ({1'b0, r_w} + len - dd);
        ib_full = (ia_full == '0) ? (len - 13'd1) : (ia_full - 13'd1);
        g_cl = i_feedback_gain;
        if (r_protect && (g_cl > GAIN_LIMIT)) begin
            g_cl = GAIN_LIMIT;
        end
        if (r_protect && (g_cl < -GAIN_LIMIT)) begin
            g_cl = -GAIN_LIMIT;
        end
        den   = 17'd256 + {1'b0, r_coef};
        diff  = 25'(r_rdata) - 25'(r_a);
        iprod = 43'(diff) * 43'($signed({1'b0, r_f}));
        isum  = iprod + (43'(r_a) <<< 16) + 43'sd32768;
        num   = (42'(r_res) <<< 8) + 42'(r_filt) * 42'($signed({1'b0, r_coef}))
              + 42'($signed({1'b0, den >> 1}));
        nmag  = r_num[41] ? 42'(-r_num + 42'($signed({1'b0, den})) - 42'sd1) : 42'(r_num);
        rem2  = {r_rem, r_q[DIV_STEPS-1]};
        ge    = rem2 >= {1'b0, den};
        qs    = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        fprod = 40'(r_res) * 40'(r_g);
        fsh   = (fprod + 40'sd8192) >>> 14;
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_w;
        wdata = r_wv;
        raddr = r_w;
        unique case (i_cmd.op)
            OP_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr_addr;
                wdata = '0;
            end
            OP_WRITE: we = 1'b1;
            OP_RDA:   raddr = r_ia;
            OP_RDB:   raddr = r_ib;
            default:  raddr = r_w;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem_store[waddr] <= wdata;
        end
        r_rdata <= r_mem_store[raddr];
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_x    <= i_in_sample;
                r_g    <= g_cl;
                r_prod <= 34'(i_delay_ms) * 34'(r_spm);
            end
            OP_MUTE:   r_res <= '0;
            OP_ADDR: begin
                r_ia <= ia_full[ADDR_W-1:0];
                r_ib <= ib_full[ADDR_W-1:0];
                r_f  <= fr;
            end
            OP_RDB:    r_a <= r_rdata;
            OP_INTERP: r_res <= r_interp ? isum[39:16] : r_a;
            OP_LPMUL:  r_num <= num;
            OP_LPPREP: begin
                r_neg <= r_num[41];
                r_rem <= {1'b0, nmag[41:26]};
                r_q   <= nmag[25:0];
                r_cnt <= '0;
            end
            OP_DIV: begin
                r_rem <= ge ? 17'(rem2 - {1'b0, den}) : rem2[16:0];
                r_q   <= {r_q[DIV_STEPS-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
            end
            OP_LPFIN:  r_res <= sat_sample(48'(qs));
            OP_FB:     r_wv <= sat_sample(48'(fsh) + 48'(r_x));
            OP_HCAP:   r_res <= r_rdata;
            OP_EMIT:   r_out <= r_res;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg   <= 13'd2205;
            r_spm       <= 16'd11290;
            r_coef      <= 16'd128;
            r_mute      <= 1'b0;
            r_hold      <= 1'b0;
            r_interp    <= 1'b1;
            r_lowpass   <= 1'b0;
            r_protect   <= 1'b0;
            r_w         <= '0;
            r_filt      <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DELAY_LENGTH:   r_len_cfg <= i_cfg_data[12:0];
                    CFG_SAMPLES_PER_MS: r_spm <= i_cfg_data;
                    CFG_FILTER_COEF:    r_coef <= i_cfg_data;
                    CFG_MUTE_ON:        r_mute <= i_cfg_data[0];
                    CFG_HOLD_ON:        r_hold <= i_cfg_data[0];
                    CFG_INTERP_ON:      r_interp <= i_cfg_data[0];
                    CFG_LOWPASS_ON:     r_lowpass <= i_cfg_data[0];
                    CFG_PROTECT_ON:     r_protect <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            unique case (i_cmd.op)
                OP_CLEAR: r_clr_addr <= r_clr_addr + 1'b1;
                OP_LOAD:  r_w <= w_eff[ADDR_W-1:0];
                OP_LPFIN: r_filt <= sat_sample(48'(qs));
                OP_WRITE: r_w <= nw[ADDR_W-1:0];
                OP_HCAP:  r_w <= nw[ADDR_W-1:0];
                default: begin
                end
            endcase
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.in_valid = i_in_valid;
    assign o_status.mute     = r_mute;
    assign o_status.hold     = r_hold;
    assign o_status.lowpass  = r_lowpass;
    assign o_status.clr_last = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign o_status.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out;
endmodule
`default_nettype wire

// ===== design/vfdl_ctrl.sv =====
`default_nettype none
`include "variable_feedback_delay_line_core_defines.svh"
module vfdl_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire vfdl_pkg::t_status i_status,
    output vfdl_pkg::t_cmd         o_cmd
);
    import vfdl_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (i_status.clr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (i_status.in_valid) begin
                    priority if (i_status.mute) n_state = S_OUT;
                    else if (i_status.hold)     n_state = S_HRD;
                    else                        n_state = S_ADDR;
                end
            end
            S_ADDR:   n_state = S_RDA;
            S_RDA:    n_state = S_RDB;
            S_RDB:    n_state = S_INTERP;
            S_INTERP: n_state = i_status.lowpass ? S_LPMUL : S_FB;
            S_LPMUL:  n_state = S_LPPREP;
            S_LPPREP: n_state = S_DIV;
            S_DIV:    if (i_status.div_last) n_state = S_LPFIN;
            S_LPFIN:  n_state = S_FB;
            S_FB:     n_state = S_WRITE;
            S_WRITE:  n_state = S_OUT;
            S_HRD:    n_state = S_HCAP;
            S_HCAP:   n_state = S_OUT;
            S_OUT:    if (i_status.out_free) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd.op       = OP_NONE;
        o_cmd.in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR:  o_cmd.op = OP_CLEAR;
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    o_cmd.op = i_status.mute ? OP_MUTE : OP_LOAD;
                end
            end
            S_ADDR:   o_cmd.op = OP_ADDR;
            S_RDA:    o_cmd.op = OP_RDA;
            S_RDB:    o_cmd.op = OP_RDB;
            S_INTERP: o_cmd.op = OP_INTERP;
            S_LPMUL:  o_cmd.op = OP_LPMUL;
            S_LPPREP: o_cmd.op = OP_LPPREP;
            S_DIV:    o_cmd.op = OP_DIV;
            S_LPFIN:  o_cmd.op = OP_LPFIN;
            S_FB:     o_cmd.op = OP_FB;
            S_WRITE:  o_cmd.op = OP_WRITE;
            S_HRD:    o_cmd.op = OP_HRD;
            S_HCAP:   o_cmd.op = OP_HCAP;
            S_OUT:    if (i_status.out_free) o_cmd.op = OP_EMIT;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    `VFDL_ASSERT_NEXT(a_mute_direct, i_clk, i_rst_n, (r_state == S_IDLE) && i_status.in_valid && i_status.mute, r_state == S_OUT)
    `VFDL_ASSERT_NEXT(a_div_done, i_clk, i_rst_n, (r_state == S_DIV) && i_status.div_last, r_state == S_LPFIN)
    `VFDL_ASSERT_IMPL(a_no_take_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_cmd.in_ready && (o_cmd.op == OP_CLEAR))
endmodule
`default_nettype wire

// ===== design/variable_feedback_delay_line_core.sv =====
// Variable feedback delay line. After reset the block clears the whole delay
// store and takes no word meanwhile. An ordinary word then passes address,
// two store reads, interpolation, feedback and write; with the lowpass on, a
// restoring divider gives one quotient bit a cycle, 26 in all. Held words read
// the store once and are not written back; an ordinary word reads it twice for
// the two interpolation taps and writes it once. One result waits in the
// output register while the next word may already be accepted.
`default_nettype none
module variable_feedback_delay_line_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [vfdl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [vfdl_pkg::CFG_W-1:0]     i_cfg_data,
    vfdl_in_if.sink                             i_in,
    vfdl_out_if.source                          o_out
);
    import vfdl_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign i_in.ready = cmd.in_ready;

    vfdl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    vfdl_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in.valid),
        .i_in_sample     (i_in.in_sample),
        .i_delay_ms      (i_in.delay_ms),
        .i_feedback_gain (i_in.feedback_gain),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_out_sample    (o_out.out_sample)
    );
endmodule
`default_nettype wire
